// ----- rtl/asgr_pkg.sv -----
// ----------------------------------------------------------------------------
// asgr_pkg
// Shared codes, character constants and helpers for the SGR attribute unit.
// ----------------------------------------------------------------------------
package asgr_pkg;

  // Parser phase codes
  localparam logic [1:0] PH_ESC     = 2'd0;
  localparam logic [1:0] PH_BRACKET = 2'd1;
  localparam logic [1:0] PH_PARAMS  = 2'd2;
  localparam logic [1:0] PH_DONE    = 2'd3;

  // Result status codes
  localparam logic [1:0] ST_APPLIED = 2'd0;
  localparam logic [1:0] ST_DEFAULT = 2'd1;
  localparam logic [1:0] ST_REJECT  = 2'd2;

  // Characters of the sequence
  localparam logic [7:0] CH_ESC     = 8'h1B;
  localparam logic [7:0] CH_LBRACK  = 8'h5B;
  localparam logic [7:0] CH_SEMI    = 8'h3B;
  localparam logic [7:0] CH_FINAL_M = 8'h6D;
  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_NINE    = 8'h39;

  // Parameter value ranges
  localparam logic [6:0] ATTR_MAX = 7'd8;
  localparam logic [6:0] FG_LO    = 7'd30;
  localparam logic [6:0] FG_HI    = 7'd37;
  localparam logic [6:0] BG_LO    = 7'd40;
  localparam logic [6:0] BG_HI    = 7'd47;
  localparam logic [6:0] ACC_SAT  = 7'd99;

  localparam int unsigned ATTR_W = 16;
  localparam int unsigned CHAR_W = 8;

  typedef logic [ATTR_W-1:0] attr_t;

  // ANSI colour index (red bit 0) to console flags (blue bit 0)
  function automatic logic [2:0] colour_flags(input logic [2:0] idx);
    colour_flags = {idx[0], idx[1], idx[2]};
  endfunction

endpackage

// ----- rtl/asgr_in_if.sv -----
// ----------------------------------------------------------------------------
// asgr_in_if
// Character request channel: one escape-string character per request.
// ----------------------------------------------------------------------------
interface asgr_in_if;
  logic                          valid;
  logic                          ready;
  logic [asgr_pkg::CHAR_W-1:0]   ch;
  logic                          last_char;

  modport source (output valid, output ch, output last_char, input ready);
  modport sink   (input valid, input ch, input last_char, output ready);
endinterface

// ----- rtl/asgr_out_if.sv -----
// ----------------------------------------------------------------------------
// asgr_out_if
// Result request channel: status and attribute word of one sequence.
// ----------------------------------------------------------------------------
interface asgr_out_if;
  logic                valid;
  logic                ready;
  logic [1:0]          status;
  asgr_pkg::attr_t     attr_word;

  modport source (output valid, output status, output attr_word, input ready);
  modport sink   (input valid, input status, input attr_word, output ready);
endinterface

// ----- rtl/asgr_cfg_if.sv -----
// ----------------------------------------------------------------------------
// asgr_cfg_if
// Configuration write channel for the default attribute register.
// ----------------------------------------------------------------------------
interface asgr_cfg_if;
  logic                valid;
  logic                ready;
  asgr_pkg::attr_t     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ----- rtl/ansi_sgr_to_text_attribute_unit.sv -----
// ----------------------------------------------------------------------------
// ansi_sgr_to_text_attribute_unit
// Parses ANSI SGR escape strings into console text attribute words.
// ----------------------------------------------------------------------------
// Usage:
//   src : one character per request (ch, last_char marks the string end).
//   dst : one result per string (status, attr_word), issued at the character
//         that settles the outcome; later characters up to the marked last
//         one produce nothing.
//   cfg : writes default_attr; the write also loads the stored last attribute.
//         cfg is always ready; write it only while the unit is idle.
// Pipeline:
//   A character is taken into the input register, then parsed by one level of
//   logic into the result register, which presents the result on dst. One
//   character per cycle is sustained while dst does not hold results off; the
//   input register advances whenever the result register is empty or drained
//   in the same cycle.
// Reset (rst, synchronous): parser waits for ESC, default_attr and the last
//   attribute return to 7, both registers are emptied.
// Stall: while dst is held off, one result and one more character are held;
//   src.ready then drops until dst takes the result.
// ----------------------------------------------------------------------------
module ansi_sgr_to_text_attribute_unit (
  input  logic          clk,
  input  logic          rst,
  asgr_in_if.sink       src,
  asgr_out_if.source    dst,
  asgr_cfg_if.sink      cfg
);

  // Input register
  logic                          s1_valid;
  logic [asgr_pkg::CHAR_W-1:0]   s1_ch;
  logic                          s1_last;
  logic                          s1_advance;
  logic                          cfg_fire;

  // Parser state
  logic [1:0]       phase, phase_next;
  logic [6:0]       number_acc, number_acc_next;
  logic [3:0]       parsed_attr, parsed_attr_next;
  logic             fg_valid, fg_valid_next;
  logic [2:0]       fg_color, fg_color_next;
  logic             bg_valid, bg_valid_next;
  logic [2:0]       bg_color, bg_color_next;
  asgr_pkg::attr_t  last_attr, last_attr_next;
  asgr_pkg::attr_t  default_attr;

  // Result register
  logic             out_valid;
  logic [1:0]       out_status;
  asgr_pkg::attr_t  out_word;

  // Parse results
  logic             res_valid;
  logic [1:0]       res_status;
  asgr_pkg::attr_t  res_word;

  logic             is_digit;
  logic [9:0]       acc_sum;
  logic [6:0]       acc_sat;
  logic             apply_ok;
  logic [3:0]       ap_attr;
  logic             ap_fg_valid;
  logic [2:0]       ap_fg_color;
  logic             ap_bg_valid;
  logic [2:0]       ap_bg_color;
  logic [6:0]       fg_off;
  logic [6:0]       bg_off;
  logic             do_reject;
  logic             do_accept;
  asgr_pkg::attr_t  applied_word;

  assign s1_advance = s1_valid && (!out_valid || dst.ready);
  assign src.ready  = !s1_valid || s1_advance;
  assign cfg.ready  = 1'b1;
  assign cfg_fire   = cfg.valid;

  assign dst.valid     = out_valid;
  assign dst.status    = out_status;
  assign dst.attr_word = out_word;

  // Take a character into the input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (src.valid && src.ready) begin
      s1_valid <= 1'b1;
    end else if (s1_advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (src.valid && src.ready) begin
      s1_ch   <= src.ch;
      s1_last <= src.last_char;
    end
  end

  // Accumulate a decimal digit, saturating at 99
  assign is_digit = (s1_ch >= asgr_pkg::CH_ZERO) && (s1_ch <= asgr_pkg::CH_NINE);
  assign acc_sum  = ({3'b000, number_acc} << 3) + ({3'b000, number_acc} << 1)
                  + {6'd0, s1_ch[3:0]};
  assign acc_sat  = (acc_sum > {3'b000, asgr_pkg::ACC_SAT}) ? asgr_pkg::ACC_SAT
                                                            : acc_sum[6:0];

  // Classify the finished parameter
  assign fg_off = number_acc - asgr_pkg::FG_LO;
  assign bg_off = number_acc - asgr_pkg::BG_LO;

  always_comb begin
    apply_ok    = 1'b1;
    ap_attr     = parsed_attr;
    ap_fg_valid = fg_valid;
    ap_fg_color = fg_color;
    ap_bg_valid = bg_valid;
    ap_bg_color = bg_color;
    if (number_acc <= asgr_pkg::ATTR_MAX) begin
      ap_attr = number_acc[3:0];
    end else if (number_acc >= asgr_pkg::FG_LO && number_acc <= asgr_pkg::FG_HI) begin
      ap_fg_valid = 1'b1;
      ap_fg_color = fg_off[2:0];
    end else if (number_acc >= asgr_pkg::BG_LO && number_acc <= asgr_pkg::BG_HI) begin
      ap_bg_valid = 1'b1;
      ap_bg_color = bg_off[2:0];
    end else begin
      apply_ok = 1'b0;
    end
  end

  // Build the new attribute from the last one
  always_comb begin
    applied_word = last_attr;
    if (ap_fg_valid) begin
      applied_word[3:0] = {ap_attr == 4'd1, asgr_pkg::colour_flags(ap_fg_color)};
    end
    if (ap_bg_valid) begin
      applied_word[7:4] = {ap_attr == 4'd1, asgr_pkg::colour_flags(ap_bg_color)};
    end
  end

  // Parse one character
  always_comb begin
    phase_next       = phase;
    number_acc_next  = number_acc;
    parsed_attr_next = parsed_attr;
    fg_valid_next    = fg_valid;
    fg_color_next    = fg_color;
    bg_valid_next    = bg_valid;
    bg_color_next    = bg_color;
    last_attr_next   = last_attr;
    do_reject        = 1'b0;
    do_accept        = 1'b0;
    res_valid        = 1'b0;
    res_status       = asgr_pkg::ST_REJECT;
    res_word         = last_attr;

    unique case (phase)
      asgr_pkg::PH_ESC: begin
        if (s1_ch != asgr_pkg::CH_ESC || s1_last) begin
          do_reject = 1'b1;
        end else begin
          phase_next = asgr_pkg::PH_BRACKET;
        end
      end
      asgr_pkg::PH_BRACKET: begin
        if (s1_ch != asgr_pkg::CH_LBRACK) begin
          do_reject = 1'b1;
        end else if (s1_last) begin
          // Sequence state is clear here, so this yields the default
          do_accept = 1'b1;
        end else begin
          phase_next = asgr_pkg::PH_PARAMS;
        end
      end
      asgr_pkg::PH_PARAMS: begin
        if (is_digit) begin
          number_acc_next = acc_sat;
          do_reject       = s1_last;
        end else if (s1_ch == asgr_pkg::CH_SEMI || s1_ch == asgr_pkg::CH_FINAL_M) begin
          if (!apply_ok) begin
            do_reject = 1'b1;
          end else begin
            number_acc_next  = 7'd0;
            parsed_attr_next = ap_attr;
            fg_valid_next    = ap_fg_valid;
            fg_color_next    = ap_fg_color;
            bg_valid_next    = ap_bg_valid;
            bg_color_next    = ap_bg_color;
            do_accept        = (s1_ch == asgr_pkg::CH_FINAL_M) || s1_last;
          end
        end else begin
          do_reject = 1'b1;
        end
      end
      asgr_pkg::PH_DONE: begin
        if (s1_last) begin
          phase_next = asgr_pkg::PH_ESC;
        end
      end
      default: begin
        phase_next = asgr_pkg::PH_ESC;
      end
    endcase

    // Settle the outcome and clear the sequence
    if (do_accept) begin
      if (ap_attr == 4'd0 && !ap_fg_valid && !ap_bg_valid) begin
        res_status = asgr_pkg::ST_DEFAULT;
        res_word   = default_attr;
      end else begin
        res_status     = asgr_pkg::ST_APPLIED;
        res_word       = applied_word;
        last_attr_next = applied_word;
      end
    end
    if (do_accept || do_reject) begin
      res_valid  = 1'b1;
      phase_next = s1_last ? asgr_pkg::PH_ESC : asgr_pkg::PH_DONE;
    end
    if (do_accept || do_reject || (phase == asgr_pkg::PH_DONE && s1_last)) begin
      number_acc_next  = 7'd0;
      parsed_attr_next = 4'd0;
      fg_valid_next    = 1'b0;
      fg_color_next    = 3'd0;
      bg_valid_next    = 1'b0;
      bg_color_next    = 3'd0;
    end
  end

  // Advance the parser state; a register write reloads the last attribute
  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= asgr_pkg::PH_ESC;
      number_acc   <= 7'd0;
      parsed_attr  <= 4'd0;
      fg_valid     <= 1'b0;
      fg_color     <= 3'd0;
      bg_valid     <= 1'b0;
      bg_color     <= 3'd0;
      last_attr    <= asgr_pkg::attr_t'(7);
      default_attr <= asgr_pkg::attr_t'(7);
    end else begin
      if (s1_advance) begin
        phase       <= phase_next;
        number_acc  <= number_acc_next;
        parsed_attr <= parsed_attr_next;
        fg_valid    <= fg_valid_next;
        fg_color    <= fg_color_next;
        bg_valid    <= bg_valid_next;
        bg_color    <= bg_color_next;
        last_attr   <= last_attr_next;
      end
      if (cfg_fire) begin
        default_attr <= cfg.data;
        last_attr    <= cfg.data;
      end
    end
  end

  // Hold the result until dst takes it
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_advance) begin
      out_valid <= res_valid;
    end else if (dst.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_advance && res_valid) begin
      out_status <= res_status;
      out_word   <= res_word;
    end
  end

  // Applied result matches the stored last attribute
  a_applied_stored: assert property (@(posedge clk) disable iff (rst)
    (s1_advance && res_valid && res_status == asgr_pkg::ST_APPLIED && !cfg_fire)
    |=> (dst.attr_word == last_attr))
    else $error("applied attribute not stored as last attribute");

  // Rejection leaves the last attribute alone
  a_reject_keeps: assert property (@(posedge clk) disable iff (rst)
    (s1_advance && res_valid && res_status == asgr_pkg::ST_REJECT && !cfg_fire)
    |=> $stable(last_attr))
    else $error("rejected sequence changed last attribute");

  // Back-pressure only when both registers are full and dst stalls
  a_ready_low: assert property (@(posedge clk) disable iff (rst)
    !src.ready |-> (s1_valid && out_valid && !dst.ready))
    else $error("input stalled without a full pipeline");

  // Reset empties the pipeline and restarts the parser
  a_reset_state: assert property (@(posedge clk)
    rst |=> (phase == asgr_pkg::PH_ESC && !out_valid && !s1_valid))
    else $error("reset did not restart the parser");

endmodule
